/* rtl/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the radix string converter
// Widths, register indexes, state codes and the character/digit helpers.
// ----------------------------------------------------------------------------
package rsc_pkg;

   // Bits of the wrapped accumulator value
   localparam int VALUE_BITS = 32;
   // Digit count holds 0..VALUE_BITS; store index holds 0..VALUE_BITS-1
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int IDX_W      = $clog2(VALUE_BITS);
   localparam int CHAR_W     = 8;
   localparam int BASE_W     = 6;
   localparam int STEP_W     = $clog2(BASE_W);
   // Signed digit value of one character: -55..200
   localparam int DVAL_W     = CHAR_W + 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;
   localparam logic [CHAR_W-1:0] CH_A      = 8'd65;
   localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'd97;
   localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'd122;
   localparam logic [CHAR_W-1:0] CASE_DIFF = CH_LOW_A - CH_A;
   localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd10;

   localparam logic [BASE_W-1:0] MIN_OUT_BASE    = 6'd2;
   localparam logic [BASE_W-1:0] RST_INPUT_BASE  = 6'd10;
   localparam logic [BASE_W-1:0] RST_OUTPUT_BASE = 6'd2;

   // Register indexes (byte address bit 2)
   localparam logic REG_INPUT_BASE  = 1'b0;
   localparam logic REG_OUTPUT_BASE = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_FOLD = 5'b00100,
      S_DIV  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [BASE_W-1:0] base;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // Signed digit value of an ASCII character
   function automatic logic signed [DVAL_W-1:0] char_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] up;
      begin
         up = c;
         if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            up = c - CASE_DIFF;
         end
         if (c >= CH_ZERO && c <= CH_NINE) begin
            char_value = $signed({1'b0, c}) - $signed({1'b0, CH_ZERO});
         end else begin
            char_value = $signed({1'b0, up}) - $signed({1'b0, CH_A})
                       + $signed({1'b0, LETTER_OFFSET});
         end
      end
   endfunction

   // ASCII character of a digit
   function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
      begin
         if ({2'b00, d} < LETTER_OFFSET) begin
            digit_char = CH_ZERO + {2'b00, d};
         end else begin
            digit_char = CH_A + {2'b00, d} - LETTER_OFFSET;
         end
      end
   endfunction

   // Output base with the floor of two applied
   function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
      begin
         eff_base = (b < MIN_OUT_BASE) ? MIN_OUT_BASE : b;
      end
   endfunction

endpackage

/* rtl/rsc_req_if.sv */
// ----------------------------------------------------------------------------
// rsc_req_if: character channel
// Valid/ready channel carrying one input character and its final flag.
// ----------------------------------------------------------------------------
interface rsc_req_if;
   import rsc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              is_final;

   modport source (output valid, output digit_char, output is_final, input ready);
   modport sink   (input valid, input digit_char, input is_final, output ready);
endinterface

/* rtl/rsc_rsp_if.sv */
// ----------------------------------------------------------------------------
// rsc_rsp_if: digit channel
// Valid/ready channel carrying one converted character with its flags.
// ----------------------------------------------------------------------------
interface rsc_rsp_if;
   import rsc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              out_last;
   logic              bad_digit;

   modport source (output valid, output out_char, output out_last, output bad_digit,
                   input ready);
   modport sink   (input valid, input out_char, input out_last, input bad_digit,
                   output ready);
endinterface

/* rtl/rsc_divider.sv */
// ----------------------------------------------------------------------------
// rsc_divider: bit-serial restoring divider
// Divides the value by a 6-bit base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  rsc_pkg::div_ctl_type              ctl,
   input  logic [rsc_pkg::VALUE_BITS-1:0]    dividend,
   output rsc_pkg::div_sts_type              sts,
   output logic [rsc_pkg::VALUE_BITS-1:0]    quotient,
   output logic [rsc_pkg::BASE_W-1:0]        remainder
);
   import rsc_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [IDX_W-1:0]      bit_ff, bit_in;
   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [BASE_W-1:0]     r_ff, r_in;
   logic [BASE_W-1:0]     base_ff, base_in;

   logic [BASE_W:0]       r_shift;
   logic                  fits;

   // Shift one dividend bit into the partial remainder, subtract if it fits
   assign r_shift = {r_ff, q_ff[VALUE_BITS-1]};
   assign fits    = (r_shift >= {1'b0, base_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      base_in = base_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         bit_in  = '0;
         q_in    = dividend;
         r_in    = '0;
         base_in = ctl.base;
      end else if (busy_ff) begin
         q_in   = {q_ff[VALUE_BITS-2:0], fits};
         r_in   = fits ? BASE_W'(r_shift - {1'b0, base_ff}) : r_shift[BASE_W-1:0];
         bit_in = bit_ff + 1'b1;
         if (bit_ff == IDX_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bit_ff  <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      r_ff    <= r_in;
      base_ff <= base_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

/* rtl/radix_string_converter.sv */
// ----------------------------------------------------------------------------
// radix_string_converter: ASCII number conversion between radixes
// Folds incoming digit characters into a wrapped value and emits its digits
// in the output radix, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one character per item; is_final marks the last one. Each
//   character goes through accept, 6 shift-add steps over the bits of
//   input_base, and one fold step that adds the digit value.
//   On a final character the value goes through a bit-serial divider: every
//   output digit is one full division of the 32-bit value, each quotient
//   feeding the next division, and the first digit reaches rsp through the
//   S_EMIT state and the output register once the last division is done.
//   rsp then carries the digits, most significant first, one per cycle while
//   the receiver takes them; out_last marks the final digit and bad_digit is
//   set on every digit if any character of the number was invalid.
//   req.ready is high only while the block waits for a character; the next
//   number may start while the final digit still waits in the rsp register.
//   A stall on rsp holds the current digit and pauses the emission.
//   The csr APB port holds input_base (address 0) and output_base (address 4);
//   write them only while idle. Reset sets bases to 10 and 2 and clears the
//   value, the error flag and both channels.
// ----------------------------------------------------------------------------
module radix_string_converter (
   input  logic                              clock,
   input  logic                              reset,
   rsc_req_if.sink                           req,
   rsc_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rsc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rsc_pkg::*;

   // Configuration registers
   logic [BASE_W-1:0]     ibase_ff, ibase_in;
   logic [BASE_W-1:0]     obase_ff, obase_in;
   logic                  csr_write;

   // Control state
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  err_ff, err_in;
   logic                  final_ff, final_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] prod_ff, prod_in;
   logic [BASE_W-1:0]     bsh_ff, bsh_in;
   logic signed [DVAL_W-1:0] dval_ff, dval_in;
   logic [BASE_W-1:0]     store_ff [VALUE_BITS];
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   // Combinational helpers
   logic                  req_take;
   logic                  rsp_load;
   logic                  store_we;
   logic signed [DVAL_W-1:0] cur_val;
   logic                  cur_bad;
   logic [VALUE_BITS-1:0] fold_sum;
   logic [IDX_W-1:0]      rd_idx;

   div_ctl_type           div_ctl;
   div_sts_type           div_sts;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_quot;
   logic [BASE_W-1:0]     div_rem;

   // ---------------------------------------------------------------------
   // APB register port: zero wait states, write on the access phase
   // ---------------------------------------------------------------------
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      ibase_in = ibase_ff;
      obase_in = obase_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_INPUT_BASE:  ibase_in = csr_pwdata[BASE_W-1:0];
            REG_OUTPUT_BASE: obase_in = csr_pwdata[BASE_W-1:0];
            default:         ibase_in = ibase_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_INPUT_BASE:  csr_prdata = CSR_DATA_W'(ibase_ff);
         REG_OUTPUT_BASE: csr_prdata = CSR_DATA_W'(obase_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Character decode at accept time
   // ---------------------------------------------------------------------
   assign req.ready = (state_ff == S_IDLE);
   assign req_take  = req.valid & req.ready;
   assign cur_val   = char_value(req.digit_char);
   // Negative values and values at or above the input base are invalid
   assign cur_bad   = cur_val[DVAL_W-1] |
                      (cur_val[CHAR_W-1:0] >= {{(CHAR_W-BASE_W){1'b0}}, ibase_ff});

   // Add the sign-extended digit value to the finished product
   assign fold_sum  = prod_ff + VALUE_BITS'(dval_ff);

   // Emission reads digits back from the top of the store
   assign rd_idx    = IDX_W'(cnt_ff - 1'b1);
   assign rsp_load  = (state_ff == S_EMIT) & (~rsp_valid_ff | rsp.ready);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      final_in     = final_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      bsh_in       = bsh_ff;
      dval_in      = dval_ff;
      store_we     = 1'b0;
      div_ctl      = '{start: 1'b0, base: eff_base(obase_ff)};
      div_dividend = div_quot;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               // Latch the digit, load the base bits, start the product
               dval_in  = cur_val;
               final_in = req.is_final;
               err_in   = err_ff | cur_bad;
               prod_in  = '0;
               bsh_in   = ibase_ff;
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // One base bit per cycle, most significant first
            prod_in = {prod_ff[VALUE_BITS-2:0], 1'b0} + (bsh_ff[BASE_W-1] ? acc_ff : '0);
            bsh_in  = {bsh_ff[BASE_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(BASE_W - 1)) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            if (final_ff) begin
               // Hand the value to the divider and clear for the next number
               acc_in        = '0;
               cnt_in        = '0;
               div_ctl.start = 1'b1;
               div_dividend  = fold_sum;
               state_in      = S_DIV;
            end else begin
               acc_in   = fold_sum;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               store_we = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               if ((div_quot != '0) && (cnt_ff < CNT_W'(VALUE_BITS - 1))) begin
                  div_ctl.start = 1'b1;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  err_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register: hold while stalled, reload from the store
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = digit_char(store_ff[rd_idx]);
         rsp_last_in  = (cnt_ff == CNT_W'(1));
         rsp_bad_in   = err_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_char  = rsp_char_ff;
   assign rsp.out_last  = rsp_last_ff;
   assign rsp.bad_digit = rsp_bad_ff;

   rsc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .sts       (div_sts),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ibase_ff     <= RST_INPUT_BASE;
         obase_ff     <= RST_OUTPUT_BASE;
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         final_ff     <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ibase_ff     <= ibase_in;
         obase_ff     <= obase_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         final_ff     <= final_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      bsh_ff      <= bsh_in;
      dval_ff     <= dval_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
      if (store_we) begin
         store_ff[cnt_ff[IDX_W-1:0]] <= div_rem;
      end
   end

`ifndef SYNTHESIS
   // The divider is never running while a character can be taken
   a_div_idle_on_take: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !div_sts.busy)
      else $error("divider busy while accepting a character");

   // The digit count never passes the value width
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(VALUE_BITS))
      else $error("digit count out of range");

   // Emission always has a digit to read
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (cnt_ff != '0))
      else $error("emission with empty digit store");

   // Loading the last digit returns the block to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (cnt_ff == CNT_W'(1))) |=> (state_ff == S_IDLE) && rsp_last_ff)
      else $error("last digit did not end the number");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the radix string converter
// Streams numbers as digit characters over several input/output radix
// settings. A scoreboard folds each accepted character into its own value,
// expands every final character into the expected output digits, and checks
// each emitted digit against the oldest one that is still waiting.
// ----------------------------------------------------------------------------
module tb_top;
   import rsc_pkg::*;

   // One emitted digit as the result channel carries it
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              bad;
   } digit_item_type;

   // Scoreboard: tracks the running value and the error flag of the current
   // number, and holds the digits that the block still owes us.
   class conversion_checker_type;
      logic [VALUE_BITS-1:0] value    = '0;
      logic                  bad_seen = 1'b0;
      logic [BASE_W-1:0]     in_base  = RST_INPUT_BASE;
      logic [BASE_W-1:0]     out_base = RST_OUTPUT_BASE;
      digit_item_type        awaited[$];
      int                    fail_count;
      int                    numbers_done;
      int                    digits_done;

      function void set_base(logic idx, logic [BASE_W-1:0] b);
         if (idx == REG_INPUT_BASE) begin
            in_base = b;
         end else begin
            out_base = b;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Fold one accepted character; on a final one, queue the digits it owes
      function void note_char(logic [CHAR_W-1:0] c, logic fin);
         int                    dval;
         logic [CHAR_W-1:0]     up;
         logic [BASE_W-1:0]     radix;
         logic [VALUE_BITS-1:0] rest;
         logic [BASE_W-1:0]     rev[$];
         digit_item_type        it;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            dval = int'(c) - int'(CH_ZERO);
         end else begin
            up = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - (CH_LOW_A - CH_A) : c;
            dval = int'(up) - int'(CH_A) + int'(LETTER_OFFSET);
         end
         if (dval < 0 || dval >= int'(in_base)) begin
            bad_seen = 1'b1;
         end
         // negative digit values enter the sum in two's complement
         value = value * {{(VALUE_BITS - BASE_W){1'b0}}, in_base} + VALUE_BITS'(dval);
         if (fin) begin
            radix = (out_base < MIN_OUT_BASE) ? MIN_OUT_BASE : out_base;
            rest  = value;
            do begin
               rev.push_front(BASE_W'(rest % VALUE_BITS'(radix)));
               rest = rest / VALUE_BITS'(radix);
            end while (rest != 0 && rev.size() < VALUE_BITS);
            foreach (rev[k]) begin
               if (CHAR_W'(rev[k]) < LETTER_OFFSET) begin
                  it.ch = CH_ZERO + CHAR_W'(rev[k]);
               end else begin
                  it.ch = CH_A + CHAR_W'(rev[k]) - LETTER_OFFSET;
               end
               it.last = (k == rev.size() - 1);
               it.bad  = bad_seen;
               awaited.push_back(it);
            end
            value    = '0;
            bad_seen = 1'b0;
            numbers_done++;
         end
      endfunction

      // Compare one emitted digit with the oldest one waiting
      function void check_digit(digit_item_type got);
         digit_item_type want;
         digits_done++;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected digit: expected none, actual char %h last %b bad %b",
                     $time, got.ch, got.last, got.bad);
            fail_count++;
            return;
         end
         want = awaited.pop_front();
         if (got.ch !== want.ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, got.ch);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, want.last, got.last);
            fail_count++;
         end
         if (got.bad !== want.bad) begin
            $display("%0t: bad_digit mismatch: expected %b, actual %b",
                     $time, want.bad, got.bad);
            fail_count++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rsc_req_if req_ch ();
   rsc_rsp_if rsp_ch ();

   conversion_checker_type conv_sb = new;

   // Odds (percent) that a sender gap goes in front of a character or a receiver stall starts on a cycle
   int gap_pct   = 0;
   int stall_pct = 0;
   int chars_sent;
   int settings_done;

   radix_string_converter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Hard stop in case the block hangs; far beyond the slowest legal run
   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver side: hold ready high, drop it in short random bursts so that
   // stalls land anywhere in the emission of a number.
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Result monitor: every accepted digit goes to the scoreboard. Values are
   // read right after the edge, before any update of this time step lands.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         conv_sb.check_digit(digit_item_type'{rsp_ch.out_char, rsp_ch.out_last,
                                              rsp_ch.bad_digit});
      end
   end

   // Read one register back over APB and compare it with what we think it holds
   task automatic reg_read(input logic idx, input logic [BASE_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== CSR_DATA_W'(want)) begin
         $display("%0t: register %0d readback: expected %h, actual %h",
                  $time, idx, CSR_DATA_W'(want), got);
         conv_sb.fail_count++;
      end
   endtask

   // APB write: setup cycle, then access cycle; the write lands when pready is seen
   task automatic reg_write(input logic idx, input logic [BASE_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      conv_sb.set_base(idx, val);
      reg_read(idx, val);
   endtask

   // Offer one character and hold it until the block takes it. An optional
   // gap with valid low goes in front; valid gets one assignment per edge.
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.digit_char <= c;
      req_ch.is_final   <= fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      conv_sb.note_char(c, fin);
      chars_sent++;
   endtask

   // Mostly a legal digit of the given radix in either letter case; now and
   // then any byte at all, which exercises the bad-digit path and every bit.
   function automatic logic [CHAR_W-1:0] pick_char(input logic [BASE_W-1:0] b);
      int d;
      int top;
      if ($urandom_range(0, 99) < 12) begin
         return CHAR_W'($urandom_range(0, 255));
      end
      // radix 0 has no legal digit at all; pick from the whole alphabet then
      top = (b == 0 || b > 36) ? 36 : int'(b);
      d   = $urandom_range(0, top - 1);
      if (d < int'(LETTER_OFFSET)) begin
         return CHAR_W'(int'(CH_ZERO) + d);
      end
      if ($urandom_range(0, 1) == 1) begin
         return CHAR_W'(int'(CH_LOW_A) + d - int'(LETTER_OFFSET));
      end
      return CHAR_W'(int'(CH_A) + d - int'(LETTER_OFFSET));
   endfunction

   // Whole numbers of random length; a few are long enough to wrap the value
   task automatic send_numbers(input int n_chars);
      int sent;
      int len;
      sent = 0;
      while (sent < n_chars) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            send_char(pick_char(conv_sb.in_base), k == len - 1);
         end
         sent += len;
      end
   endtask

   // Drop valid, drain every owed digit, then let the divider and the
   // emit register run dry before anyone touches the registers.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (conv_sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // One radix setting: program both bases while idle, then stream numbers
   task automatic run_phase(input logic [BASE_W-1:0] ib, input logic [BASE_W-1:0] ob,
                            input int n_chars, input int busy_pct);
      settle();
      reg_write(REG_INPUT_BASE, ib);
      reg_write(REG_OUTPUT_BASE, ob);
      gap_pct   = busy_pct;
      stall_pct = busy_pct;
      settings_done++;
      send_numbers(n_chars);
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.digit_char <= '0;
      req_ch.is_final   <= 1'b0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of both bases must read back
      reg_read(REG_INPUT_BASE, RST_INPUT_BASE);
      reg_read(REG_OUTPUT_BASE, RST_OUTPUT_BASE);

      // Directed numbers at the reset setting (decimal in, binary out)
      settings_done = 1;
      send_char(CH_ZERO, 1'b1);       // zero value: a lone "0" marked last
      send_char("1", 1'b0);
      send_char("2", 1'b0);
      send_char("3", 1'b1);
      send_char("a", 1'b1);           // lowercase letter, too big for decimal
      send_char(8'h00, 1'b1);         // lowest byte: negative digit value wraps
      send_char(8'hff, 1'b1);         // highest byte
      send_char("z", 1'b0);           // error on a non-final character ...
      send_char("/", 1'b1);           // ... and a negative value on the final one
      send_char("7", 1'b1);           // error flag must be clear again
      for (int k = 0; k < 11; k++) begin
         send_char("9", k == 10);     // eleven nines wrap the 32-bit value
      end

      // Radix settings, extremes included; calm stretches come between the busy ones
      run_phase(6'd16, 6'd16, 40, 25);
      run_phase(6'd2,  6'd36, 40, 0);
      run_phase(6'd36, 6'd2,  40, 30);
      run_phase(6'd0,  6'd1,  30, 25);
      run_phase(6'd1,  6'd0,  30, 0);
      run_phase(6'd63, 6'd63, 30, 30);
      run_phase(6'd8,  6'd37, 40, 25);
      run_phase(6'd36, 6'd36, 40, 0);
      run_phase(BASE_W'($urandom_range(2, 36)), BASE_W'($urandom_range(2, 36)), 30, 30);
      run_phase(BASE_W'($urandom_range(2, 36)), BASE_W'($urandom_range(2, 36)), 30, 20);
      // Final stretch at full rate on both sides
      run_phase(6'd10, 6'd10, 40, 0);

      settle();
      repeat (80) @(posedge clock);

      $display("Run covered %0d numbers from %0d characters, %0d digits checked",
               conv_sb.numbers_done, chars_sent, conv_sb.digits_done);
      $display("Radix settings used: %0d, from 0 and 1 up to 63 on both sides",
               settings_done);
      if (conv_sb.fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/rsc_pkg.sv
rtl/rsc_req_if.sv
rtl/rsc_rsp_if.sv
rtl/rsc_divider.sv
rtl/radix_string_converter.sv
test/tb_top.sv
